// ===== hw/rtl/qtr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtr_pkg
// Shared types and constants of the quarter-turn image rotator.
// ----------------------------------------------------------------------------
package qtr_pkg;

  localparam int QTR_MAX_WIDTH  = 64;
  localparam int QTR_MAX_HEIGHT = 64;
  localparam int CFG_DIM_W      = 7;
  localparam int CFG_TURN_W     = 2;
  localparam int CMD_DEPTH      = 4;
  localparam int OUT_DEPTH      = 4;

  localparam logic [CFG_DIM_W-1:0]  RST_WIDTH  = 7'd64;
  localparam logic [CFG_DIM_W-1:0]  RST_HEIGHT = 7'd64;
  localparam logic [CFG_TURN_W-1:0] RST_TURNS  = 2'd1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TURNS  = 2'd2;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_ERROR = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    PH_LOAD    = 2'b01,
    PH_READOUT = 2'b10
  } phase_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      hit;
    logic      last;
    rgb_t      pix;
  } cmd_t;

  typedef struct packed {
    rgb_t pix;
    logic last;
    logic err;
  } res_t;

endpackage

// ===== hw/rtl/qtr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtr_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module qtr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== hw/rtl/qtr_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtr_fifo
// Small first-word-fall-through queue built from registers.
// ----------------------------------------------------------------------------
module qtr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/qtr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtr_front
// Accepts items, tracks load and readout position, issues store commands.
// ----------------------------------------------------------------------------
module qtr_front import qtr_pkg::*; #(
  parameter int MAX_WIDTH  = QTR_MAX_WIDTH,
  parameter int MAX_HEIGHT = QTR_MAX_HEIGHT,
  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT,
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int DW      = $clog2(MAX_DIM + 1),
  localparam int RW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int LW      = $clog2(DEPTH + 1),
  localparam int PW      = 2 * DW,
  localparam int SW      = DW + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  mode,
  input  rgb_t                  pix,
  input  logic [CFG_DIM_W-1:0]  image_width,
  input  logic [CFG_DIM_W-1:0]  image_height,
  input  logic [CFG_TURN_W-1:0] quarter_turns,
  input  logic                  cmd_full,
  output logic                  cmd_push,
  output cmd_t                  cmd,
  output logic [AW-1:0]         cmd_addr
);

  localparam logic signed [SW-1:0] ONE_S = SW'(1);

  phase_t        phase;
  logic [LW-1:0] lcount;
  logic [RW-1:0] rrow;
  logic [RW-1:0] rcol;

  logic [DW-1:0] wc, hc, ow, oh, col_inc, row_inc;
  logic signed [SW-1:0] rs, cs, ws, hs, sr, sc;
  logic [PW-1:0] lin, area;
  logic [LW-1:0] load_inc;
  logic          hit, last_col, last, load_done, store_ok;

  always_comb begin
    if (image_width == '0) begin
      wc = DW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      wc = DW'(MAX_WIDTH);
    end else begin
      wc = DW'(image_width);
    end
    if (image_height == '0) begin
      hc = DW'(1);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      hc = DW'(MAX_HEIGHT);
    end else begin
      hc = DW'(image_height);
    end
  end

  assign rs = signed'(SW'(rrow));
  assign cs = signed'(SW'(rcol));
  assign ws = signed'(SW'(wc));
  assign hs = signed'(SW'(hc));

  always_comb begin
    case (quarter_turns)
      2'd0: begin
        sr = rs;
        sc = cs;
      end
      2'd1: begin
        sr = hs - ONE_S - cs;
        sc = rs;
      end
      2'd2: begin
        sr = hs - ONE_S - rs;
        sc = ws - ONE_S - cs;
      end
      default: begin
        sr = cs;
        sc = ws - ONE_S - rs;
      end
    endcase
  end

  assign hit = !sr[SW-1] && !sc[SW-1] && (sr < hs) && (sc < ws);
  assign lin = PW'(sr[DW-1:0]) * PW'(wc) + PW'(sc[DW-1:0]);

  assign ow       = quarter_turns[0] ? hc : wc;
  assign oh       = quarter_turns[0] ? wc : hc;
  assign col_inc  = DW'(rcol) + DW'(1);
  assign row_inc  = DW'(rrow) + DW'(1);
  assign last_col = (col_inc >= ow);
  assign last     = last_col && (row_inc >= oh);

  assign area      = PW'(wc) * PW'(hc);
  assign load_inc  = lcount + LW'(1);
  assign load_done = (PW'(load_inc) >= area);
  assign store_ok  = (int'(lcount) < DEPTH);

  assign cmd_push = push && !cmd_full;

  always_comb begin
    cmd.kind = CMD_ERROR;
    cmd.hit  = 1'b0;
    cmd.last = 1'b0;
    cmd.pix  = pix;
    cmd_addr = lcount[AW-1:0];
    if (mode == MODE_WRITE) begin
      if (phase == PH_LOAD) begin
        cmd.kind = CMD_WRITE;
        cmd.hit  = store_ok;
      end
    end else begin
      if (phase == PH_READOUT) begin
        cmd.kind = CMD_READ;
        cmd.hit  = hit;
        cmd.last = last;
        cmd_addr = lin[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_LOAD;
      lcount <= '0;
      rrow   <= '0;
      rcol   <= '0;
    end else if (cmd_push) begin
      if (mode == MODE_WRITE && phase == PH_LOAD) begin
        lcount <= load_inc;
        if (load_done) begin
          phase <= PH_READOUT;
          rrow  <= '0;
          rcol  <= '0;
        end
      end else if (mode == MODE_READ && phase == PH_READOUT) begin
        if (last_col) begin
          rcol <= '0;
          if (last) begin
            rrow   <= '0;
            phase  <= PH_LOAD;
            lcount <= '0;
          end else begin
            rrow <= rrow + 1'b1;
          end
        end else begin
          rcol <= rcol + 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/qtr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtr_back
// Executes store commands on the frame store and queues the results.
// ----------------------------------------------------------------------------
module qtr_back import qtr_pkg::*; #(
  parameter int MAX_WIDTH  = QTR_MAX_WIDTH,
  parameter int MAX_HEIGHT = QTR_MAX_HEIGHT,
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int OCW   = $clog2(OUT_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  input  logic [AW-1:0] cmd_addr,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  output res_t          res,
  output logic          res_empty,
  input  logic          res_pop
);

  logic           room;
  logic           ram_en;
  logic           ram_we;
  rgb_t           ram_rdata;
  logic           pend_valid;
  logic           pend_hit;
  logic           pend_last;
  logic           pend_err;
  res_t           res_in;
  logic           res_full;
  logic [OCW-1:0] res_count;

  assign room    = ((OCW + 1)'(res_count) + (OCW + 1)'(pend_valid)) < (OCW + 1)'(OUT_DEPTH);
  assign cmd_pop = !cmd_empty && ((cmd.kind == CMD_WRITE) || room);
  assign ram_we  = (cmd.kind == CMD_WRITE);
  assign ram_en  = cmd_pop && cmd.hit && ((cmd.kind == CMD_WRITE) || (cmd.kind == CMD_READ));

  qtr_ram #(
    .WIDTH ($bits(rgb_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (cmd_addr),
    .wdata (cmd.pix),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= cmd_pop && (cmd.kind != CMD_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      pend_hit  <= cmd.hit && (cmd.kind == CMD_READ);
      pend_last <= cmd.last && (cmd.kind == CMD_READ);
      pend_err  <= (cmd.kind != CMD_READ);
    end
  end

  always_comb begin
    res_in.pix  = pend_hit ? ram_rdata : '0;
    res_in.last = pend_last;
    res_in.err  = pend_err;
  end

  qtr_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (pend_valid),
    .din   (res_in),
    .full  (res_full),
    .pop   (res_pop),
    .dout  (res),
    .empty (res_empty),
    .count (res_count)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !res_full)
    else $error("result pushed into full queue");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && cmd.kind == CMD_WRITE) |=> !pend_valid)
    else $error("write produced a result");

  a_hit_has_read: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && pend_hit) |-> $past(ram_en && !ram_we))
    else $error("pixel result without store read");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && pend_err) |-> (!pend_hit && !pend_last))
    else $error("error result carries pixel or last flag");

endmodule

// ===== hw/rtl/quarter_turn_image_rotator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quarter_turn_image_rotator_unit
// Frame store that loads an RGB image and reads it back rotated.
// ----------------------------------------------------------------------------
// Load a frame with write items in raster order, then take it back with read
// items, one pixel each, rotated clockwise by quarter_turns quarter turns; the
// read that returns the final pixel flags last_pixel and the unit returns to
// loading. A write during readout or a read during loading returns an error
// result. One item is taken per clock when results are drained; each item
// makes at most one access to the single-port frame store, which sets that
// rate. A result passes the command queue, the store read and the result
// queue before it reaches the result ports. Writes give no result.
module quarter_turn_image_rotator_unit import qtr_pkg::*; #(
  parameter int MAX_WIDTH  = QTR_MAX_WIDTH,
  parameter int MAX_HEIGHT = QTR_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic [7:0]  pixel_red,
  input  logic [7:0]  pixel_green,
  input  logic [7:0]  pixel_blue,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        last_pixel,
  output logic        access_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW    = $bits(cmd_t) + AW;

  logic [CFG_DIM_W-1:0]  image_width;
  logic [CFG_DIM_W-1:0]  image_height;
  logic [CFG_TURN_W-1:0] quarter_turns;

  rgb_t          pix;
  logic          cmd_push;
  cmd_t          cmd_in;
  logic [AW-1:0] addr_in;
  logic [QW-1:0] q_dout;
  cmd_t          cmd_q;
  logic [AW-1:0] addr_q;
  logic          cmd_empty;
  logic          cmd_pop;
  res_t          res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= RST_WIDTH;
      image_height  <= RST_HEIGHT;
      quarter_turns <= RST_TURNS;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_WIDTH:  image_width   <= pwdata[CFG_DIM_W-1:0];
        REG_HEIGHT: image_height  <= pwdata[CFG_DIM_W-1:0];
        REG_TURNS:  quarter_turns <= pwdata[CFG_TURN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      REG_TURNS:  prdata = 32'(quarter_turns);
      default:    prdata = '0;
    endcase
  end

  assign pix.red   = pixel_red;
  assign pix.green = pixel_green;
  assign pix.blue  = pixel_blue;

  qtr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .mode          (mode),
    .pix           (pix),
    .image_width   (image_width),
    .image_height  (image_height),
    .quarter_turns (quarter_turns),
    .cmd_full      (full),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in),
    .cmd_addr      (addr_in)
  );

  qtr_fifo #(
    .WIDTH (QW),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   ({cmd_in, addr_in}),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (q_dout),
    .empty (cmd_empty),
    .count ()
  );

  assign {cmd_q, addr_q} = q_dout;

  qtr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_q),
    .cmd_addr  (addr_q),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res       (res),
    .res_empty (empty),
    .res_pop   (pop)
  );

  assign out_red      = res.pix.red;
  assign out_green    = res.pix.green;
  assign out_blue     = res.pix.blue;
  assign last_pixel   = res.last;
  assign access_error = res.err;

endmodule
